// ===== rtl/mset_pkg.sv =====
// shared types, codes and reset constants for the multitouch slot event tracker
// no dependencies
package mset_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int COORD_W        = 16;
    localparam int RADIUS_W       = 10;
    localparam int RADIUS_SQ_W    = 2 * RADIUS_W;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [RADIUS_W-1:0]    MOVE_RADIUS_RST = 10'd10;
    localparam logic [RADIUS_SQ_W-1:0] RADIUS_SQ_RST   = RADIUS_SQ_W'(10 * 10);
    localparam logic [COORD_W-1:0]     SCREEN_W_RST    = 16'd720;
    localparam logic [COORD_W-1:0]     SCREEN_H_RST    = 16'd1280;

    typedef enum logic [1:0] {
        FUNC_SLOT  = 2'd0,
        FUNC_X     = 2'd1,
        FUNC_Y     = 2'd2,
        FUNC_TOUCH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_DOWN = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_UP   = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONNECTED   = 2'd0,
        CFG_MOVE_RADIUS = 2'd1,
        CFG_SCREEN_W    = 2'd2,
        CFG_SCREEN_H    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         touch_id;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        t_action            action;
        logic               pressure;
        logic [COORD_W-1:0] width_out;
        logic [COORD_W-1:0] height_out;
    } t_result;

endpackage

// ===== rtl/mset_in_reg.sv =====
// input register stage: holds one accepted event until the slot logic takes it
// depends on mset_pkg
module mset_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [1:0]                    i_func,
    input  logic [mset_pkg::COORD_W-1:0]  i_value,
    output logic                          o_stall,
    input  logic                          i_go,
    output logic                          o_valid,
    output logic [1:0]                    o_func,
    output logic [mset_pkg::COORD_W-1:0]  o_value
);

    logic                         r_valid;
    logic [1:0]                   r_func;
    logic [mset_pkg::COORD_W-1:0] r_value;
    logic                         w_accept;

    assign o_stall  = r_valid && !i_go;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_go) begin
            r_valid <= 1'b0;
        end
        if (w_accept) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_func  = r_func;
    assign o_value = r_value;

endmodule

// ===== rtl/mset_slot_core.sv =====
// per-slot touch state, configuration registers and event decision
// depends on mset_pkg
module mset_slot_core #(
    parameter int SLOT_COUNT = mset_pkg::SLOT_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mset_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mset_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    input  logic [1:0]                       i_func,
    input  logic [mset_pkg::COORD_W-1:0]     i_value,
    input  logic                             i_out_free,
    output logic                             o_go,
    output logic                             o_emit,
    output mset_pkg::t_result                o_result
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = mset_pkg::COORD_W;
    localparam int QW = mset_pkg::SQ_W;

    logic                               r_connected;
    logic [mset_pkg::RADIUS_SQ_W-1:0]   r_radius_sq;
    logic [CW-1:0]                      r_screen_w;
    logic [CW-1:0]                      r_screen_h;

    logic [SW-1:0] r_sel;
    logic [CW-1:0] r_cur_x  [SLOT_COUNT];
    logic [CW-1:0] r_cur_y  [SLOT_COUNT];
    logic [CW-1:0] r_prev_x [SLOT_COUNT];
    logic [CW-1:0] r_prev_y [SLOT_COUNT];
    logic [QW-1:0] r_dx_sq  [SLOT_COUNT];
    logic [QW-1:0] r_dy_sq  [SLOT_COUNT];
    logic          r_pressed[SLOT_COUNT];

    mset_pkg::t_func               w_func;
    logic [CW-1:0]                 w_ref;
    logic [CW-1:0]                 w_diff;
    logic [QW-1:0]                 w_sq;
    logic [QW:0]                   w_dist;
    logic                          w_far;
    logic                          w_new_p;
    logic                          w_prev_p;
    logic [SW-1:0]                 n_sel;
    logic [mset_pkg::RADIUS_W-1:0] w_radius;

    assign w_func = mset_pkg::t_func'(i_func);

    // squared distance on one axis is kept up to date as coordinates arrive,
    // so the touch event only adds and compares
    always_comb begin
        w_ref  = (w_func == mset_pkg::FUNC_Y) ? r_prev_y[r_sel] : r_prev_x[r_sel];
        w_diff = (i_value >= w_ref) ? (i_value - w_ref) : (w_ref - i_value);
        w_sq   = {{CW{1'b0}}, w_diff} * {{CW{1'b0}}, w_diff};
    end

    assign w_dist   = {1'b0, r_dx_sq[r_sel]} + {1'b0, r_dy_sq[r_sel]};
    assign w_far    = w_dist >= (QW + 1)'(r_radius_sq);
    assign w_new_p  = |i_value;
    assign w_prev_p = r_pressed[r_sel];
    assign n_sel    = (i_value < CW'(SLOT_COUNT)) ? SW'(i_value) : '0;
    assign w_radius = i_cfg_data[mset_pkg::RADIUS_W-1:0];

    assign o_emit = (w_func == mset_pkg::FUNC_TOUCH) && r_connected &&
                    ((w_prev_p != w_new_p) || (w_prev_p && w_new_p && w_far));
    assign o_go   = i_valid && (!o_emit || i_out_free);

    always_comb begin
        o_result.touch_id   = 3'(r_sel);
        o_result.pos_x      = r_cur_x[r_sel];
        o_result.pos_y      = r_cur_y[r_sel];
        o_result.pressure   = w_new_p;
        o_result.width_out  = r_screen_w;
        o_result.height_out = r_screen_h;
        if (w_new_p && !w_prev_p) begin
            o_result.action = mset_pkg::ACT_DOWN;
        end else if (w_new_p) begin
            o_result.action = mset_pkg::ACT_MOVE;
        end else begin
            o_result.action = mset_pkg::ACT_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connected <= 1'b0;
            r_radius_sq <= mset_pkg::RADIUS_SQ_RST;
            r_screen_w  <= mset_pkg::SCREEN_W_RST;
            r_screen_h  <= mset_pkg::SCREEN_H_RST;
        end else if (i_cfg_we) begin
            case (mset_pkg::t_cfg_idx'(i_cfg_index))
                mset_pkg::CFG_CONNECTED:   r_connected <= i_cfg_data[0];
                mset_pkg::CFG_MOVE_RADIUS: r_radius_sq <=
                    mset_pkg::RADIUS_SQ_W'(w_radius) * mset_pkg::RADIUS_SQ_W'(w_radius);
                mset_pkg::CFG_SCREEN_W:    r_screen_w  <= i_cfg_data;
                mset_pkg::CFG_SCREEN_H:    r_screen_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_cur_x[i]   <= '0;
                r_cur_y[i]   <= '0;
                r_prev_x[i]  <= '0;
                r_prev_y[i]  <= '0;
                r_dx_sq[i]   <= '0;
                r_dy_sq[i]   <= '0;
                r_pressed[i] <= 1'b0;
            end
        end else if (o_go) begin
            case (w_func)
                mset_pkg::FUNC_SLOT: begin
                    r_sel <= n_sel;
                end
                mset_pkg::FUNC_X: begin
                    r_cur_x[r_sel] <= i_value;
                    r_dx_sq[r_sel] <= w_sq;
                end
                mset_pkg::FUNC_Y: begin
                    r_cur_y[r_sel] <= i_value;
                    r_dy_sq[r_sel] <= w_sq;
                end
                mset_pkg::FUNC_TOUCH: begin
                    // current report becomes the previous one, distance back to zero
                    r_prev_x[r_sel]  <= r_cur_x[r_sel];
                    r_prev_y[r_sel]  <= r_cur_y[r_sel];
                    r_pressed[r_sel] <= w_new_p;
                    r_dx_sq[r_sel]   <= '0;
                    r_dy_sq[r_sel]   <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/mset_out_reg.sv =====
// output register stage: holds one result until the receiver takes it
// depends on mset_pkg
module mset_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mset_pkg::t_result  i_result,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output mset_pkg::t_result  o_result
);

    logic              r_valid;
    mset_pkg::t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/multitouch_slot_event_tracker.sv =====
// top level of the multitouch slot event tracker
// depends on mset_pkg, mset_in_reg, mset_slot_core, mset_out_reg
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  event in | input     | i_valid / o_stall  | i_func, i_value
//  result   | output    | o_valid / i_stall  | o_touch_id, o_pos_x, o_pos_y, o_action,
//           |           |                    | o_pressure, o_width_out, o_height_out
//  config   | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// one transaction per cycle is taken in while o_stall is low; each waits in
// the input register; its result is loaded on the same edge as its slot update
// the per-axis squared distance is refreshed on coordinate events, so one
// 16x16 multiplier serves x and y and the touch path is one add and compare
// synchronous active-low reset clears the slot state and loads register defaults
// a held result blocks only transactions that would emit; the input register keeps
// taking new transactions while the result waits, until one that would emit is held
module multitouch_slot_event_tracker #(
    parameter int SLOT_COUNT = mset_pkg::SLOT_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mset_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mset_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // event channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_func,
    input  logic [mset_pkg::COORD_W-1:0]     i_value,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [2:0]                       o_touch_id,
    output logic [mset_pkg::COORD_W-1:0]     o_pos_x,
    output logic [mset_pkg::COORD_W-1:0]     o_pos_y,
    output logic [1:0]                       o_action,
    output logic                             o_pressure,
    output logic [mset_pkg::COORD_W-1:0]     o_width_out,
    output logic [mset_pkg::COORD_W-1:0]     o_height_out
);

    // input register outputs
    logic                         w_in_valid;
    logic [1:0]                   w_in_func;
    logic [mset_pkg::COORD_W-1:0] w_in_value;

    // handshake between slot logic and output register
    logic              w_go;
    logic              w_emit;
    logic              w_out_free;
    mset_pkg::t_result w_result;
    mset_pkg::t_result w_out_result;

    mset_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_value (i_value),
        .o_stall (o_stall),
        .i_go    (w_go),
        .o_valid (w_in_valid),
        .o_func  (w_in_func),
        .o_value (w_in_value)
    );

    // slot select, coordinate store, configuration registers, touch compare and event decision
    mset_slot_core #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_in_valid),
        .i_func      (w_in_func),
        .i_value     (w_in_value),
        .i_out_free  (w_out_free),
        .o_go        (w_go),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    // only emitting transactions load the result register
    mset_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_go && w_emit),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_result (w_out_result)
    );

    assign o_touch_id   = w_out_result.touch_id;
    assign o_pos_x      = w_out_result.pos_x;
    assign o_pos_y      = w_out_result.pos_y;
    assign o_action     = w_out_result.action;
    assign o_pressure   = w_out_result.pressure;
    assign o_width_out  = w_out_result.width_out;
    assign o_height_out = w_out_result.height_out;

endmodule

// ===== rtl/mset_checker.sv =====
// port-level checks for the multitouch slot event tracker, bound to the top level
// depends on mset_pkg and multitouch_slot_event_tracker
module mset_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [2:0]                       o_touch_id,
    input logic [mset_pkg::COORD_W-1:0]     o_pos_x,
    input logic [mset_pkg::COORD_W-1:0]     o_pos_y,
    input logic [1:0]                       o_action,
    input logic                             o_pressure,
    input logic [mset_pkg::COORD_W-1:0]     o_width_out,
    input logic [mset_pkg::COORD_W-1:0]     o_height_out
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_touch_id) && $stable(o_pos_x) &&
            $stable(o_pos_y) && $stable(o_action) && $stable(o_pressure) &&
            $stable(o_width_out) && $stable(o_height_out))
        else $error("result payload changed while stalled");

    // reset empties the result register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a fresh result follows an accepted transaction
    a_rise_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && $past(i_rst_n) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a matching transaction");

    // pressure is set for down and move, clear for up, and the action is a known one
    a_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pressure == (o_action != mset_pkg::ACT_UP)) &&
            (o_action == mset_pkg::ACT_DOWN || o_action == mset_pkg::ACT_MOVE ||
             o_action == mset_pkg::ACT_UP))
        else $error("pressure does not match action");

endmodule

bind multitouch_slot_event_tracker mset_checker u_mset_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_touch_id   (o_touch_id),
    .o_pos_x      (o_pos_x),
    .o_pos_y      (o_pos_y),
    .o_action     (o_action),
    .o_pressure   (o_pressure),
    .o_width_out  (o_width_out),
    .o_height_out (o_height_out)
);

// ===== dv/mset_tb_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the multitouch slot event tracker: per-slot touch state tracking,
// expected event queue and field-by-field comparison of emitted events
// depends on mset_pkg
package mset_tb_pkg;
    import mset_pkg::*;

    class slot_event_scoreboard;
        // register copies
        bit                 link_up;
        bit [RADIUS_W-1:0]  radius;
        bit [COORD_W-1:0]   scr_w;
        bit [COORD_W-1:0]   scr_h;
        // per-slot touch reports
        int unsigned        sel_slot;
        bit [COORD_W-1:0]   cur_x   [SLOT_COUNT_DEF];
        bit [COORD_W-1:0]   cur_y   [SLOT_COUNT_DEF];
        bit                 cur_down[SLOT_COUNT_DEF];
        bit [COORD_W-1:0]   last_x  [SLOT_COUNT_DEF];
        bit [COORD_W-1:0]   last_y  [SLOT_COUNT_DEF];
        bit                 last_down[SLOT_COUNT_DEF];
        t_result            due_events[$];
        int unsigned        fail_count;

        function new();
            link_up    = 1'b0;
            radius     = MOVE_RADIUS_RST;
            scr_w      = SCREEN_W_RST;
            scr_h      = SCREEN_H_RST;
            sel_slot   = 0;
            fail_count = 0;
            foreach (cur_x[i]) begin
                cur_x[i]     = '0;
                cur_y[i]     = '0;
                cur_down[i]  = 1'b0;
                last_x[i]    = '0;
                last_y[i]    = '0;
                last_down[i] = 1'b0;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CONNECTED:   link_up = data[0];
                CFG_MOVE_RADIUS: radius  = data[RADIUS_W-1:0];
                CFG_SCREEN_W:    scr_w   = data;
                CFG_SCREEN_H:    scr_h   = data;
                default: ;
            endcase
        endfunction

        function void note_input(t_func fn, logic [COORD_W-1:0] val);
            int unsigned s;
            longint      dx;
            longint      dy;
            bit          far;
            t_result     ev;
            s = sel_slot;
            case (fn)
                // out-of-range slot numbers fall back to slot 0
                FUNC_SLOT:  sel_slot = (val < SLOT_COUNT_DEF) ? int'(val) : 0;
                FUNC_X:     cur_x[s] = val;
                FUNC_Y:     cur_y[s] = val;
                FUNC_TOUCH: begin
                    cur_down[s] = (val != '0);
                    dx  = longint'(cur_x[s]) - longint'(last_x[s]);
                    dy  = longint'(cur_y[s]) - longint'(last_y[s]);
                    far = cur_down[s] && last_down[s] &&
                          (dx * dx + dy * dy >= longint'(radius) * longint'(radius));
                    if (link_up && (far || cur_down[s] != last_down[s])) begin
                        ev.touch_id   = 3'(s);
                        ev.pos_x      = cur_x[s];
                        ev.pos_y      = cur_y[s];
                        if (cur_down[s] && !last_down[s]) begin
                            ev.action   = ACT_DOWN;
                            ev.pressure = 1'b1;
                        end else if (cur_down[s]) begin
                            ev.action   = ACT_MOVE;
                            ev.pressure = 1'b1;
                        end else begin
                            ev.action   = ACT_UP;
                            ev.pressure = 1'b0;
                        end
                        ev.width_out  = scr_w;
                        ev.height_out = scr_h;
                        due_events.push_back(ev);
                    end
                    // previous report follows the current one, emitted or not
                    last_x[s]    = cur_x[s];
                    last_y[s]    = cur_y[s];
                    last_down[s] = cur_down[s];
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [COORD_W-1:0] want,
                                    logic [COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_event(t_result got);
            t_result want;
            if (due_events.size() == 0) begin
                $error("event with none outstanding: touch_id %0d action %0d",
                       got.touch_id, got.action);
                fail_count++;
                return;
            end
            want = due_events.pop_front();
            compare_field("touch_id",   want.touch_id,   got.touch_id);
            compare_field("pos_x",      want.pos_x,      got.pos_x);
            compare_field("pos_y",      want.pos_y,      got.pos_y);
            compare_field("action",     want.action,     got.action);
            compare_field("pressure",   want.pressure,   got.pressure);
            compare_field("width_out",  want.width_out,  got.width_out);
            compare_field("height_out", want.height_out, got.height_out);
        endfunction

        function int unsigned outstanding();
            return due_events.size();
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// top-level testbench for the multitouch slot event tracker: directed and random
// touch traffic with random idling on both channels and register changes between phases
// depends on mset_pkg, mset_tb_pkg and the multitouch_slot_event_tracker rtl
module tb_top;
    import mset_pkg::*;
    import mset_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    // input register plus slot update plus output register, with margin
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 115;

    // touch state values carried on a touch transaction
    localparam logic [COORD_W-1:0] TOUCH_UP   = 16'd0;
    localparam logic [COORD_W-1:0] TOUCH_DOWN = 16'd1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_func;
    logic [COORD_W-1:0]    i_value;
    logic                  o_valid;
    logic                  i_stall;
    logic [2:0]            o_touch_id;
    logic [COORD_W-1:0]    o_pos_x;
    logic [COORD_W-1:0]    o_pos_y;
    logic [1:0]            o_action;
    logic                  o_pressure;
    logic [COORD_W-1:0]    o_width_out;
    logic [COORD_W-1:0]    o_height_out;

    slot_event_scoreboard sb = new();

    // idling percentages, changed per phase
    int unsigned         tx_idle_pct;
    int unsigned         rx_idle_pct;
    // long receiver hold-off, requested by the stimulus and counted by the receiver
    bit                  hold_req;
    int unsigned         hold_left;
    int unsigned         items_sent;
    int unsigned         cycle_count;
    // stimulus-side view of the touch points, used to aim moves around the radius
    logic [RADIUS_W-1:0] gen_radius;
    logic [COORD_W-1:0]  gen_x[SLOT_COUNT_DEF];
    logic [COORD_W-1:0]  gen_y[SLOT_COUNT_DEF];
    int unsigned         gen_slot;
    t_result             got_event;

    multitouch_slot_event_tracker DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_touch_id   (o_touch_id),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_action     (o_action),
        .o_pressure   (o_pressure),
        .o_width_out  (o_width_out),
        .o_height_out (o_height_out)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // watchdog: a lost or stuck event ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result channel: sample at the rising edge, a transaction moves when not stalled
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_event = {o_touch_id, o_pos_x, o_pos_y, o_action, o_pressure,
                         o_width_out, o_height_out};
            sb.check_event(got_event);
        end
    end

    // receiver stall, updated on the falling edge; a hold-off request wins over idling
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // offer one event transaction; entered and left on a falling edge
    task automatic offer(input t_func fn, input logic [COORD_W-1:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(fn, val);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding event, then let the pipe empty
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write all four registers back to back; only called with the block idle
    task automatic write_regs(input logic [CFG_DATA_W-1:0] conn_d,
                              input logic [CFG_DATA_W-1:0] rad_d,
                              input logic [CFG_DATA_W-1:0] w_d,
                              input logic [CFG_DATA_W-1:0] h_d);
        logic [CFG_DATA_W-1:0] vals[4];
        vals       = '{conn_d, rad_d, w_d, h_d};
        gen_radius = rad_d[RADIUS_W-1:0];
        i_cfg_we  <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_reg(t_cfg_idx'(k), vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // new coordinate a little off the old one, so moves land on both sides of the radius
    function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base);
        int unsigned span;
        span = int'(gen_radius) + int'(gen_radius) / 2 + 2;
        if ($urandom_range(0, 4) == 0)
            return COORD_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            return base + COORD_W'($urandom_range(0, span));
        return base - COORD_W'($urandom_range(0, span));
    endfunction

    // mostly well-formed slot/x/y/touch reports, the rest random transactions
    task automatic random_burst(input int unsigned count);
        int unsigned          stop_at;
        int unsigned          pick;
        logic [COORD_W-1:0]   slot_val;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 80) begin
                // occasionally an out-of-range slot, which lands on slot 0
                if ($urandom_range(0, 9) == 0)
                    slot_val = COORD_W'($urandom_range(SLOT_COUNT_DEF, 65535));
                else
                    slot_val = COORD_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
                gen_slot = (slot_val < SLOT_COUNT_DEF) ? int'(slot_val) : 0;
                offer(FUNC_SLOT, slot_val);
                if ($urandom_range(0, 3) != 0) begin
                    gen_x[gen_slot] = nudge(gen_x[gen_slot]);
                    offer(FUNC_X, gen_x[gen_slot]);
                end
                if ($urandom_range(0, 3) != 0) begin
                    gen_y[gen_slot] = nudge(gen_y[gen_slot]);
                    offer(FUNC_Y, gen_y[gen_slot]);
                end
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    offer(FUNC_TOUCH, TOUCH_DOWN);
                else if (pick < 9)
                    offer(FUNC_TOUCH, TOUCH_UP);
                else
                    offer(FUNC_TOUCH, COORD_W'($urandom_range(2, 65535)));
            end else begin
                offer(t_func'($urandom_range(0, 3)), COORD_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FUNC_SLOT;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_CONNECTED;
        i_cfg_data  = '0;
        tx_idle_pct = 13;
        rx_idle_pct = 85;
        hold_req    = 1'b0;
        hold_left   = 0;
        items_sent  = 0;
        cycle_count = 0;
        gen_radius  = MOVE_RADIUS_RST;
        gen_slot    = 0;
        foreach (gen_x[i]) begin
            gen_x[i] = '0;
            gen_y[i] = '0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // link down after reset: a press is tracked but not reported
        offer(FUNC_SLOT, 16'd2);
        offer(FUNC_X, 16'd100);
        offer(FUNC_Y, 16'd200);
        offer(FUNC_TOUCH, TOUCH_DOWN);
        drain();
        write_regs(16'd1, CFG_DATA_W'(MOVE_RADIUS_RST), SCREEN_W_RST, SCREEN_H_RST);

        // release of the point pressed while the link was down
        offer(FUNC_TOUCH, TOUCH_UP);
        // slot 8 is out of range, selects slot 0; a touch value of 2 counts as pressed
        offer(FUNC_SLOT, 16'd8);
        offer(FUNC_X, 16'hFFFF);
        offer(FUNC_Y, 16'hFFFF);
        offer(FUNC_TOUCH, 16'd2);
        // 6*6 + 8*8 equals the squared radius exactly: a move
        offer(FUNC_X, 16'hFFF9);
        offer(FUNC_Y, 16'hFFF7);
        offer(FUNC_TOUCH, TOUCH_DOWN);
        // just short of the radius: nothing, but the previous report still moves on
        offer(FUNC_X, 16'hFFF0);
        offer(FUNC_TOUCH, 16'hFFFF);
        // full-scale jump, squared sum beyond 32 bits
        offer(FUNC_X, 16'h0000);
        offer(FUNC_Y, 16'h0000);
        offer(FUNC_TOUCH, TOUCH_DOWN);
        // released slot released again: no change, no event
        offer(FUNC_SLOT, 16'd7);
        offer(FUNC_TOUCH, TOUCH_UP);
        // largest slot value falls back to slot 0, then lift
        offer(FUNC_SLOT, 16'hFFFF);
        offer(FUNC_TOUCH, TOUCH_UP);
        offer(FUNC_SLOT, 16'd5);
        offer(FUNC_X, 16'h5555);
        offer(FUNC_Y, 16'hAAAA);
        offer(FUNC_TOUCH, TOUCH_DOWN);
        offer(FUNC_TOUCH, TOUCH_UP);

        // zero radius: every held touch reports a move; extreme screen sizes
        drain();
        write_regs(16'd1, 16'd0, 16'hFFFF, 16'd1);
        random_burst(PHASE_ITEMS);

        // largest radius, zero screen size copied through as is
        drain();
        tx_idle_pct = 85;
        rx_idle_pct = 13;
        write_regs(16'd1, 16'h03FF, 16'd0, 16'd0);
        random_burst(PHASE_ITEMS);

        // no idling; upper bits set in the link and radius words, radius masks to zero;
        // the receiver holds off long enough for the block to back up its input
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(16'hFFFF, 16'hFC00, COORD_W'($urandom), COORD_W'($urandom));
        hold_req = 1'b1;
        random_burst(PHASE_ITEMS);

        // link down, bit 0 clear under set upper bits: state is tracked, nothing reported
        drain();
        tx_idle_pct = 13;
        rx_idle_pct = 85;
        write_regs(16'hFFFE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        random_burst(PHASE_ITEMS);

        // small radius, with a pause mid-phase until every event has been taken
        drain();
        tx_idle_pct = 85;
        rx_idle_pct = 13;
        write_regs(16'd1, COORD_W'($urandom_range(1, 60)), SCREEN_W_RST, SCREEN_H_RST);
        random_burst(PHASE_ITEMS / 2);
        drain();
        random_burst(PHASE_ITEMS - PHASE_ITEMS / 2);

        // random radius and screen size, no idling
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(16'd1, COORD_W'($urandom_range(0, 1023)),
                   COORD_W'($urandom), COORD_W'($urandom));
        random_burst(PHASE_ITEMS);

        drain();
        if (sb.fail_count == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
